// File: rtl/olir_pkg.sv
// Package for the ordered list block: sizes, command and status codes,
// beat structs and the control struct broadcast to the entry cells.
// No dependencies.
package olir_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned ENTRY_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W       = 7;
  localparam int unsigned CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  position;
    logic        at_tail;
    logic [31:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
    logic        is_full;
    logic        is_empty;
  } out_beat_t;

  typedef struct packed {
    cell_op_e               op;
    logic [IDX_W-1:0]       pos;
    logic [ENTRY_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

// File: rtl/olir_cell.sv
// One entry cell of the ordered list chain.
// Depends on olir_pkg for the cell control struct and sizes.
module olir_cell (
  input  logic                            clk_i,
  input  olir_pkg::cell_ctrl_t            ctrl_i,
  input  logic [olir_pkg::IDX_W-1:0]      idx_i,
  input  logic [olir_pkg::ENTRY_WIDTH-1:0] left_i,
  input  logic [olir_pkg::ENTRY_WIDTH-1:0] right_i,
  output logic [olir_pkg::ENTRY_WIDTH-1:0] data_o,
  output logic [olir_pkg::ENTRY_WIDTH-1:0] rd_o
);
  import olir_pkg::*;

  logic [ENTRY_WIDTH-1:0] data_q, data_d;

  // Pick the next entry: shift up, load, shift down or hold
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (idx_i > ctrl_i.pos) begin
          data_d = left_i;
        end else if (idx_i == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      OP_REMOVE: begin
        if (idx_i >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Drive this entry onto the read bus only when addressed
  assign rd_o   = (idx_i == ctrl_i.pos) ? data_q : '0;
  assign data_o = data_q;

endmodule

// File: rtl/ordered_list_insert_remove.sv
// Ordered list with insert, remove and read; instantiates a chain of olir_cell
// entry cells and holds the count, capacity register and output register.
// Depends on olir_pkg.

// Ordered list of up to DEPTH entries. The result beat of each accepted
// command beat appears in the output register on the next cycle; a new
// command is taken every cycle as long as the result beat is drained.
// Insert and remove shift every later entry by one slot in the same cycle
// through the neighbor links of the entry cell chain, so the rate is one beat
// per cycle. The capacity register is written through cfg_we_i / cfg_wdata_i;
// values above DEPTH act as DEPTH. Entry storage has no reset: only positions
// below the count are ever read.
module ordered_list_insert_remove (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  olir_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output olir_pkg::out_beat_t  out_beat_o,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i
);
  import olir_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q;
  out_beat_t        out_beat_q, out_beat_d;

  logic             accept;
  logic [CMP_W-1:0] cnt_x, cap_x, pos_x, p_x, eff_cap, cnt_next_x;
  status_e          status;
  cell_op_e         op;
  cell_ctrl_t       ctrl;
  logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];
  logic [ENTRY_WIDTH-1:0] cell_rd   [DEPTH];
  logic [ENTRY_WIDTH-1:0] rd_bus;
  logic [63:0]      in_wide, rd_wide;

  // Stall input only while a result beat is waiting
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign cnt_x   = CMP_W'(count_q);
  assign cap_x   = CMP_W'(cap_q);
  assign pos_x   = CMP_W'(in_beat_i.position);
  assign eff_cap = (cap_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_x;

  // Decode the command and resolve the target position and status
  always_comb begin
    status  = ST_INVALID;
    op      = OP_HOLD;
    p_x     = pos_x;
    count_d = count_q;
    unique case (cmd_e'(in_beat_i.cmd))
      CMD_INSERT: begin
        p_x = in_beat_i.at_tail ? cnt_x : pos_x;
        if (p_x > cnt_x) begin
          status = ST_INVALID;
        end else if (cnt_x >= eff_cap) begin
          status = ST_FULL;
        end else begin
          status  = ST_OK;
          op      = OP_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (in_beat_i.at_tail && cnt_x == '0) begin
          status = ST_EMPTY;
        end else begin
          p_x = in_beat_i.at_tail ? (cnt_x - CMP_W'(1)) : pos_x;
          if (p_x >= cnt_x) begin
            status = ST_INVALID;
          end else begin
            status  = ST_OK;
            op      = OP_REMOVE;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      CMD_READ: begin
        if (cnt_x == '0) begin
          status = ST_EMPTY;
        end else begin
          p_x = in_beat_i.at_tail ? (cnt_x - CMP_W'(1)) : pos_x;
          status = (p_x >= cnt_x) ? ST_INVALID : ST_OK;
        end
      end
      default: status = ST_INVALID;
    endcase
  end

  // Broadcast the shift control to the cells; write only on an accepted beat
  assign in_wide    = 64'(in_beat_i.item_value);
  assign ctrl.op    = accept ? op : OP_HOLD;
  assign ctrl.pos   = p_x[IDX_W-1:0];
  assign ctrl.value = in_wide[ENTRY_WIDTH-1:0];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    olir_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(k)),
      .left_i  ((k == 0) ? '0 : cell_data[(k == 0) ? 0 : k - 1]),
      .right_i ((k == DEPTH - 1) ? '0 : cell_data[(k == DEPTH - 1) ? k : k + 1]),
      .data_o  (cell_data[k]),
      .rd_o    (cell_rd[k])
    );
  end

  // Merge the read bus: at most one cell drives a nonzero value
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  // Form the result beat
  assign cnt_next_x = CMP_W'(count_d);
  assign rd_wide    = 64'(rd_bus);
  always_comb begin
    out_beat_d.status      = status;
    out_beat_d.read_value  = (cmd_e'(in_beat_i.cmd) == CMD_READ && status == ST_OK)
                             ? rd_wide[31:0] : 32'd0;
    out_beat_d.entry_count = 7'(count_d);
    out_beat_d.is_full     = (cnt_next_x >= eff_cap);
    out_beat_d.is_empty    = (count_d == '0);
  end

  // Hold count, capacity and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CAP_W'(64);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload on each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Count never exceeds the number of cells
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(DEPTH))
    else $error("entry count above depth");

  // An accepted beat always leaves a result beat
  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

  // A successful insert grows the count by one
  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_INSERT) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow count");

  // Read data is zero on any failed command
  a_read_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.status != ST_OK) |-> (out_beat_o.read_value == 32'd0))
    else $error("read data nonzero on failed command");

endmodule
